>>> rtl/core/urs_pkg.sv
package urs_pkg;

  // measurement cycle phases; unused codes fall back to trigger low
  typedef enum logic [2:0] {
    PH_TRIG_LOW  = 3'd0,
    PH_TRIG_HIGH = 3'd1,
    PH_WAIT_RISE = 3'd2,
    PH_MEASURE   = 3'd3,
    PH_HOLD      = 3'd4
  } phase_t;

  // register indexes (byte address = 4 * index)
  localparam logic [2:0] REG_NEAR_THRESHOLD     = 3'd0;
  localparam logic [2:0] REG_VELOCITY_FACTOR    = 3'd1;
  localparam logic [2:0] REG_TRIGGER_LOW_TICKS  = 3'd2;
  localparam logic [2:0] REG_TRIGGER_HIGH_TICKS = 3'd3;
  localparam logic [2:0] REG_HOLD_TICKS         = 3'd4;
  localparam logic [2:0] REG_TICKS_PER_COUNT    = 3'd5;

  // lamp codes
  localparam logic [1:0] LAMP_NONE = 2'd0;
  localparam logic [1:0] LAMP_NEAR = 2'd1;
  localparam logic [1:0] LAMP_FAR  = 2'd2;

  // register reset values
  localparam logic [15:0] NEAR_THRESHOLD_RST     = 16'd30;
  localparam logic [9:0]  VELOCITY_FACTOR_RST    = 10'd340;
  localparam logic [9:0]  TRIGGER_LOW_TICKS_RST  = 10'd10;
  localparam logic [9:0]  TRIGGER_HIGH_TICKS_RST = 10'd10;
  localparam logic [20:0] HOLD_TICKS_RST         = 21'd1100000;
  localparam logic [7:0]  TICKS_PER_COUNT_RST    = 8'd4;

  // velocity (10b) times half count (15b)
  localparam int PROD_W = 25;
  // floor(x / 1000) = (x * ceil(2^35 / 1000)) >> 35, exact for x < 2^25
  localparam int RECIP_W = 26;
  localparam int DIV_SHIFT = 35;
  localparam logic [RECIP_W-1:0] DIV_RECIP = 26'd34359739;
  localparam int QUOT_W = PROD_W + RECIP_W;

endpackage

>>> rtl/core/ultrasonic_range_sequencer.sv
// channel   signals                          direction  transfer when
// -------   -------------------------------  ---------  -----------------------
// in        in_valid in_ready echo_level     sink       in_valid & in_ready
// out       out_valid out_ready trigger_level source     out_valid & out_ready
//           lamp_code distance_value
//           distance_valid
// cfg       psel penable pwrite paddr pwdata sink       psel & penable & pwrite
//           prdata pready
//
// one tick per cycle sustained while the out channel is not stalled; the phase
// sequencer and the velocity product sit in the first registered stage, the
// divide by 1000 (reciprocal multiply) and lamp compare in the second
// rst is synchronous: phase goes to trigger low, all counters, distance and lamp
// clear, registers take their reset values
// a stalled out channel holds both stages; in_ready drops only when both are full
module ultrasonic_range_sequencer (
  input  logic        clk,
  input  logic        rst,
  // tick channel
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        echo_level,
  // result channel
  output logic        out_valid,
  input  logic        out_ready,
  output logic        trigger_level,
  output logic [1:0]  lamp_code,
  output logic [15:0] distance_value,
  output logic        distance_valid,
  // register port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  // ---------------------------------------------------------------------------
  // configuration registers
  // ---------------------------------------------------------------------------
  logic [15:0] near_threshold;
  logic [9:0]  velocity_factor;
  logic [9:0]  trigger_low_ticks;
  logic [9:0]  trigger_high_ticks;
  logic [20:0] hold_ticks;
  logic [7:0]  ticks_per_count;

  logic       cfg_wr;
  logic [2:0] cfg_idx;

  assign pready  = 1'b1;
  assign cfg_wr  = psel & penable & pwrite;
  assign cfg_idx = paddr[4:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      near_threshold     <= urs_pkg::NEAR_THRESHOLD_RST;
      velocity_factor    <= urs_pkg::VELOCITY_FACTOR_RST;
      trigger_low_ticks  <= urs_pkg::TRIGGER_LOW_TICKS_RST;
      trigger_high_ticks <= urs_pkg::TRIGGER_HIGH_TICKS_RST;
      hold_ticks         <= urs_pkg::HOLD_TICKS_RST;
      ticks_per_count    <= urs_pkg::TICKS_PER_COUNT_RST;
    end else if (cfg_wr) begin
      case (cfg_idx)
        urs_pkg::REG_NEAR_THRESHOLD:     near_threshold     <= pwdata[15:0];
        urs_pkg::REG_VELOCITY_FACTOR:    velocity_factor    <= pwdata[9:0];
        urs_pkg::REG_TRIGGER_LOW_TICKS:  trigger_low_ticks  <= pwdata[9:0];
        urs_pkg::REG_TRIGGER_HIGH_TICKS: trigger_high_ticks <= pwdata[9:0];
        urs_pkg::REG_HOLD_TICKS:         hold_ticks         <= pwdata[20:0];
        urs_pkg::REG_TICKS_PER_COUNT:    ticks_per_count    <= pwdata[7:0];
        default: ;  // addresses past the map are ignored
      endcase
    end
  end

  // read back
  always_comb begin
    case (cfg_idx)
      urs_pkg::REG_NEAR_THRESHOLD:     prdata = {16'd0, near_threshold};
      urs_pkg::REG_VELOCITY_FACTOR:    prdata = {22'd0, velocity_factor};
      urs_pkg::REG_TRIGGER_LOW_TICKS:  prdata = {22'd0, trigger_low_ticks};
      urs_pkg::REG_TRIGGER_HIGH_TICKS: prdata = {22'd0, trigger_high_ticks};
      urs_pkg::REG_HOLD_TICKS:         prdata = {11'd0, hold_ticks};
      urs_pkg::REG_TICKS_PER_COUNT:    prdata = {24'd0, ticks_per_count};
      default:                         prdata = 32'd0;
    endcase
  end

  // ---------------------------------------------------------------------------
  // pipeline handshake
  // ---------------------------------------------------------------------------
  logic s1_valid;
  logic adv2;
  logic in_xfer;

  assign adv2     = s1_valid & (~out_valid | out_ready);
  assign in_ready = ~s1_valid | adv2;
  assign in_xfer  = in_valid & in_ready;

  // ---------------------------------------------------------------------------
  // stage 1: phase sequencer
  // ---------------------------------------------------------------------------
  urs_pkg::phase_t phase, phase_next, phase_cur;
  logic [20:0] phase_timer, phase_timer_next;
  logic [7:0]  prescale_counter, prescale_counter_next;
  logic [15:0] echo_count, echo_count_next;

  logic        hold_done;
  logic [20:0] timer_inc;
  logic [8:0]  presc_limit;
  logic [8:0]  presc_inc;
  logic        presc_wrap;
  logic        rise_wrap;
  logic        trig;
  logic        done;

  // hold phase expiring turns this tick into a trigger-low tick
  assign hold_done = (phase == urs_pkg::PH_HOLD) && (phase_timer >= hold_ticks);
  assign phase_cur = hold_done ? urs_pkg::PH_TRIG_LOW : phase;
  assign timer_inc = phase_timer + 21'd1;

  // prescaler: a zero setting counts as 256
  assign presc_limit = (ticks_per_count == 8'd0) ? 9'd256 : {1'b0, ticks_per_count};
  assign presc_inc   = {1'b0, prescale_counter} + 9'd1;
  assign presc_wrap  = presc_inc >= presc_limit;
  // first count tick on the echo rise starts from cleared counters
  assign rise_wrap   = presc_limit == 9'd1;

  // next state
  always_comb begin
    phase_next            = phase_cur;
    phase_timer_next      = phase_timer;
    prescale_counter_next = prescale_counter;
    echo_count_next       = echo_count;
    case (phase_cur)
      urs_pkg::PH_HOLD: begin
        phase_timer_next = timer_inc;
      end
      urs_pkg::PH_TRIG_HIGH: begin
        phase_timer_next = timer_inc;
        if (timer_inc >= {11'd0, trigger_high_ticks}) begin
          phase_next       = urs_pkg::PH_WAIT_RISE;
          phase_timer_next = 21'd0;
        end
      end
      urs_pkg::PH_WAIT_RISE: begin
        if (echo_level) begin
          phase_next            = urs_pkg::PH_MEASURE;
          prescale_counter_next = rise_wrap ? 8'd0 : 8'd1;
          echo_count_next       = rise_wrap ? 16'd1 : 16'd0;
        end
      end
      urs_pkg::PH_MEASURE: begin
        if (echo_level) begin
          if (presc_wrap) begin
            prescale_counter_next = 8'd0;
            echo_count_next       = echo_count + 16'd1;
          end else begin
            prescale_counter_next = presc_inc[7:0];
          end
        end else begin
          phase_next       = urs_pkg::PH_HOLD;
          phase_timer_next = 21'd0;
        end
      end
      default: begin
        // trigger low, also for unused codes
        phase_next = urs_pkg::PH_TRIG_LOW;
        if (hold_done) begin
          phase_timer_next = 21'd1;
        end else begin
          phase_timer_next = timer_inc;
        end
        if (phase_timer_next >= {11'd0, trigger_low_ticks}) begin
          phase_next       = urs_pkg::PH_TRIG_HIGH;
          phase_timer_next = 21'd0;
        end
      end
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    trig = 1'b0;
    done = 1'b0;
    case (phase_cur)
      urs_pkg::PH_TRIG_HIGH: trig = 1'b1;
      urs_pkg::PH_MEASURE:   done = ~echo_level;
      default: ;
    endcase
  end

  // distance numerator: velocity * (((count*4) mod 2^16) / 2)
  logic [14:0]                 half_count;
  logic [urs_pkg::PROD_W-1:0] prod;

  assign half_count = {echo_count[13:0], 1'b0};
  assign prod       = {{(urs_pkg::PROD_W-10){1'b0}}, velocity_factor}
                    * {{(urs_pkg::PROD_W-15){1'b0}}, half_count};

  logic                       s1_trig;
  logic                       s1_done;
  logic [urs_pkg::PROD_W-1:0] s1_prod;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase            <= urs_pkg::PH_TRIG_LOW;
      phase_timer      <= 21'd0;
      prescale_counter <= 8'd0;
      echo_count       <= 16'd0;
      s1_valid         <= 1'b0;
    end else begin
      if (in_xfer) begin
        phase            <= phase_next;
        phase_timer      <= phase_timer_next;
        prescale_counter <= prescale_counter_next;
        echo_count       <= echo_count_next;
      end
      if (in_ready) begin
        s1_valid <= in_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      s1_trig <= trig;
      s1_done <= done;
      s1_prod <= prod;
    end
  end

  // ---------------------------------------------------------------------------
  // stage 2: divide by 1000, lamp compare, result register
  // ---------------------------------------------------------------------------
  logic [urs_pkg::QUOT_W-1:0] quot_full;
  logic [15:0]                new_distance;

  assign quot_full = {{urs_pkg::RECIP_W{1'b0}}, s1_prod}
                   * {{urs_pkg::PROD_W{1'b0}}, urs_pkg::DIV_RECIP};
  // quotient stays below 2^16 for the full product range
  assign new_distance = quot_full[urs_pkg::DIV_SHIFT +: 16];

  logic [15:0] last_distance;
  logic [1:0]  lamp_state;
  logic        o_trig;
  logic        o_done;
  logic        o_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      last_distance <= 16'd0;
      lamp_state    <= urs_pkg::LAMP_NONE;
      o_valid       <= 1'b0;
    end else begin
      if (adv2 && s1_done) begin
        last_distance <= new_distance;
        lamp_state    <= (new_distance < near_threshold) ? urs_pkg::LAMP_NEAR
                                                         : urs_pkg::LAMP_FAR;
      end
      if (~out_valid | out_ready) begin
        o_valid <= s1_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv2) begin
      o_trig <= s1_trig;
      o_done <= s1_done;
    end
  end

  assign out_valid      = o_valid;
  assign trigger_level  = o_trig;
  assign distance_valid = o_done;
  assign distance_value = last_distance;
  assign lamp_code      = lamp_state;

endmodule
